/* rtl/rpsh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rpsh_pkg
// Shared types and constants for the random projection sign hash block.
// -----------------------------------------------------------------------------
package rpsh_pkg;

  // MT19937-64 generator
  localparam int unsigned TW_N  = 312;
  localparam int unsigned TW_M  = 156;
  localparam int unsigned TW_AW = 9;
  localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [31:0] TW_MUL_LO = 32'h4C95_7F2D;
  localparam logic [31:0] TW_MUL_HI = 32'h5851_F42D;
  localparam logic [63:0] GOLDEN    = 64'h9E37_79B9_7F4A_7C15;

  // bucket ID field width
  localparam int unsigned ID_W = 60;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED  = 2'd0,
    CFG_TABLE = 2'd1,
    CFG_BITS  = 2'd2,
    CFG_SPOTS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    TW_IDLE,
    TW_SEED_A,
    TW_SEED_B,
    TW_SEED_C,
    TW_REGEN,
    TW_DRAW
  } tw_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_START,
    BS_FILL
  } build_state_e;

  // one draw from the generator: only the sign bit is used
  typedef struct packed {
    logic valid;
    logic sign;
  } tw_draw_t;

endpackage
`default_nettype wire

/* rtl/rpsh_twister.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rpsh_twister
// MT19937-64 on a 312-entry state RAM; streams tempered bits (one mask differs).
// -----------------------------------------------------------------------------
module rpsh_twister (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [63:0]       seed_i,
  output rpsh_pkg::tw_draw_t     draw_o
);

  localparam logic [rpsh_pkg::TW_AW-1:0] LAST_IDX = rpsh_pkg::TW_AW'(rpsh_pkg::TW_N - 1);
  localparam logic [rpsh_pkg::TW_AW-1:0] END_IDX  = rpsh_pkg::TW_AW'(rpsh_pkg::TW_N);
  localparam logic [rpsh_pkg::TW_AW-1:0] OFS_M    = rpsh_pkg::TW_AW'(rpsh_pkg::TW_M - 1);

  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_EEDA_0000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    x = x ^ (x >> 43);
    return x;
  endfunction

  rpsh_pkg::tw_state_e state_q, state_d;

  logic [63:0] mt_mem [rpsh_pkg::TW_N];

  logic [rpsh_pkg::TW_AW-1:0] cnt_q;
  logic [rpsh_pkg::TW_AW-1:0] rj_q;
  logic [63:0] prev_q, qs_q, prod_q, prev_a_q, rd_a_q, rd_b_q;
  logic        rpend_q, dpend_q, draw_v_q, draw_s_q;

  logic                       we, issue_r, issue_d;
  logic [rpsh_pkg::TW_AW-1:0] wa, ra, rb, rb_sum;
  logic [63:0]                wd, q_mix, mul_a, mul_b, mul_c, y, regen_v, seed_val;
  logic [63:0]                tempered;

  assign q_mix = prev_q ^ (prev_q >> 62);
  assign mul_a = q_mix[31:0] * rpsh_pkg::TW_MUL_LO;
  assign mul_b = qs_q[63:32] * rpsh_pkg::TW_MUL_LO;
  assign mul_c = qs_q[31:0] * rpsh_pkg::TW_MUL_HI;
  assign seed_val = prod_q + {mul_c[31:0], 32'h0} + 64'(cnt_q);

  // y = upper 33 bits of mt[i] with lower 31 bits of mt[i+1]
  assign y       = {prev_a_q[63:31], rd_a_q[30:0]};
  assign regen_v = rd_b_q ^ (y >> 1) ^ (y[0] ? rpsh_pkg::TW_MATRIX : 64'h0);
  assign rb_sum  = cnt_q + OFS_M;
  assign tempered = temper(rd_a_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpsh_pkg::TW_IDLE:   state_d = rpsh_pkg::TW_IDLE;
      rpsh_pkg::TW_SEED_A: state_d = rpsh_pkg::TW_SEED_B;
      rpsh_pkg::TW_SEED_B: state_d = rpsh_pkg::TW_SEED_C;
      rpsh_pkg::TW_SEED_C: begin
        state_d = (cnt_q == LAST_IDX) ? rpsh_pkg::TW_REGEN : rpsh_pkg::TW_SEED_A;
      end
      rpsh_pkg::TW_REGEN:  begin
        if (cnt_q == END_IDX) state_d = rpsh_pkg::TW_DRAW;
      end
      rpsh_pkg::TW_DRAW:   begin
        if (cnt_q == LAST_IDX) state_d = rpsh_pkg::TW_REGEN;
      end
      default:             state_d = rpsh_pkg::TW_IDLE;
    endcase
    if (start_i) state_d = rpsh_pkg::TW_SEED_A;
  end

  // RAM control
  always_comb begin
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    ra      = cnt_q;
    rb      = '0;
    issue_r = 1'b0;
    issue_d = 1'b0;
    case (state_q)
      rpsh_pkg::TW_SEED_C: begin
        we = 1'b1;
        wa = cnt_q;
        wd = seed_val;
      end
      rpsh_pkg::TW_REGEN: begin
        issue_r = 1'b1;
        ra      = (cnt_q == END_IDX) ? '0 : cnt_q;
        rb      = (rb_sum >= END_IDX) ? rb_sum - END_IDX : rb_sum;
      end
      rpsh_pkg::TW_DRAW: begin
        issue_d = 1'b1;
      end
      default: begin
        issue_r = 1'b0;
      end
    endcase
    if (rpend_q && rj_q != '0) begin
      we = 1'b1;
      wa = rj_q - 1'b1;
      wd = regen_v;
    end
    if (start_i) begin
      we      = 1'b1;
      wa      = '0;
      wd      = seed_i;
      issue_r = 1'b0;
      issue_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mt_mem[wa] <= wd;
    rd_a_q <= mt_mem[ra];
    rd_b_q <= mt_mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpsh_pkg::TW_IDLE;
      cnt_q    <= '0;
      rj_q     <= '0;
      rpend_q  <= 1'b0;
      dpend_q  <= 1'b0;
      draw_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rpend_q  <= issue_r;
      dpend_q  <= issue_d;
      rj_q     <= cnt_q;
      draw_v_q <= dpend_q && !start_i;
      if (start_i) begin
        cnt_q <= rpsh_pkg::TW_AW'(1);
      end else begin
        case (state_q)
          rpsh_pkg::TW_SEED_C: cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
          rpsh_pkg::TW_REGEN:  cnt_q <= (cnt_q == END_IDX) ? '0 : cnt_q + 1'b1;
          rpsh_pkg::TW_DRAW:   cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
          default:             cnt_q <= cnt_q;
        endcase
      end
    end
  end

  // seeding multiply: one 32x32 partial product per cycle; also draw sign register
  always_ff @(posedge clk_i) begin
    draw_s_q <= tempered[0];
    if (rpend_q) prev_a_q <= rd_a_q;
    if (start_i) begin
      prev_q <= seed_i;
    end else begin
      case (state_q)
        rpsh_pkg::TW_SEED_A: begin
          qs_q   <= q_mix;
          prod_q <= mul_a;
        end
        rpsh_pkg::TW_SEED_B: prod_q[63:32] <= prod_q[63:32] + mul_b[31:0];
        rpsh_pkg::TW_SEED_C: prev_q <= seed_val;
        default:             prev_q <= prev_q;
      endcase
    end
  end

  assign draw_o.valid = draw_v_q;
  assign draw_o.sign  = draw_s_q;

endmodule
`default_nettype wire

/* rtl/random_projection_sign_hash.sv */
`timescale 1ns / 1ps
`default_nettype none
// Output: once the last sample is accepted, stage 1 sums it and its bucket ID is registered.
// Throughput: 1 sample per cycle unless held off, set by sign RAM read and parallel adders.
// Rebuild: after reset or any register write, the first sample waits while the generator
//   seeds and the sign RAM fills.
// Reset: asynchronous, active low; registers return to seed 1, table 0, 12 bits, 2048 spots.
// -----------------------------------------------------------------------------
// random_projection_sign_hash
// Signed random projection (SimHash) bucket ID per column for one hash table.
// -----------------------------------------------------------------------------
module random_projection_sign_hash #(
  parameter int unsigned MAX_BITS     = 60,
  parameter int unsigned MAX_SPOTS    = 2048,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // sample stream
  input  wire logic                                     s_axis_tvalid,
  output      logic                                     s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,  // [SW-1:0] sample_value
  // bucket ID stream
  output      logic                                     m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  output      logic [63:0]                              m_axis_tdata,  // [59:0] bucket_id
  // register writes
  input  wire logic                                     cfg_valid_i,
  output      logic                                     cfg_ready_o,
  input  wire logic [rpsh_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [rpsh_pkg::CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int unsigned BIT_W  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int unsigned NB_W   = $clog2(MAX_BITS + 1);
  localparam int unsigned SPOT_W = $clog2(MAX_SPOTS);
  localparam int unsigned NS_W   = $clog2(MAX_SPOTS + 1);
  // exact column sum: sample width plus growth over MAX_SPOTS terms, plus one
  // bit so that MAX_SPOTS negated minimum samples stay positive
  localparam int unsigned SUM_W  = SAMPLE_WIDTH + SPOT_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers; any write drops the sign matrix and the column.
  // ---------------------------------------------------------------------------
  logic [31:0] seed_q;
  logic [5:0]  table_q, bits_q;
  logic [11:0] spots_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= 32'd1;
      table_q <= 6'd0;
      bits_q  <= 6'd12;
      spots_q <= 12'd2048;
    end else if (cfg_we) begin
      case (rpsh_pkg::cfg_reg_e'(cfg_index_i))
        rpsh_pkg::CFG_SEED:  seed_q  <= cfg_data_i;
        rpsh_pkg::CFG_TABLE: table_q <= cfg_data_i[5:0];
        rpsh_pkg::CFG_BITS:  bits_q  <= cfg_data_i[5:0];
        rpsh_pkg::CFG_SPOTS: spots_q <= cfg_data_i[11:0];
        default:             seed_q  <= seed_q;
      endcase
    end
  end

  // effective bit and spot counts: zero acts as one, large values clamp
  logic [NB_W-1:0] nb_eff;
  logic [NS_W-1:0] ns_eff;

  always_comb begin
    if (bits_q == '0)                nb_eff = NB_W'(1);
    else if (int'(bits_q) > MAX_BITS) nb_eff = NB_W'(MAX_BITS);
    else                             nb_eff = NB_W'(bits_q);
    if (spots_q == '0)                 ns_eff = NS_W'(1);
    else if (int'(spots_q) > MAX_SPOTS) ns_eff = NS_W'(MAX_SPOTS);
    else                               ns_eff = NS_W'(spots_q);
  end

  // generator seed: sign-extended seed plus golden ratio times (table + 1)
  logic [63:0] tw_seed;
  assign tw_seed = {{32{seed_q[31]}}, seed_q}
                 + rpsh_pkg::GOLDEN * {57'h0, {1'b0, table_q} + 7'd1};

  // ---------------------------------------------------------------------------
  // Sign matrix build: draws arrive bit-major; each lands in one bit of a RAM
  // word. The first pass (bit 0) writes the whole word, clearing the rest.
  // ---------------------------------------------------------------------------
  rpsh_pkg::build_state_e bs_q, bs_d;
  rpsh_pkg::tw_draw_t     draw;
  logic                   tw_start, fill_we, fill_done, fs_last, fb_last;
  logic [BIT_W-1:0]       fb_q;
  logic [SPOT_W-1:0]      fs_q;
  logic                   signs_ready_q;

  assign fs_last = (NS_W'(fs_q) == ns_eff - 1'b1);
  assign fb_last = (NB_W'(fb_q) == nb_eff - 1'b1);

  rpsh_twister u_twister (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tw_start),
    .seed_i  (tw_seed),
    .draw_o  (draw)
  );

  always_comb begin
    bs_d = bs_q;
    case (bs_q)
      rpsh_pkg::BS_IDLE:  if (s_axis_tvalid && !signs_ready_q) bs_d = rpsh_pkg::BS_START;
      rpsh_pkg::BS_START: bs_d = rpsh_pkg::BS_FILL;
      rpsh_pkg::BS_FILL:  if (fill_done) bs_d = rpsh_pkg::BS_IDLE;
      default:            bs_d = rpsh_pkg::BS_IDLE;
    endcase
    if (cfg_we) bs_d = rpsh_pkg::BS_IDLE;
  end

  always_comb begin
    tw_start  = (bs_q == rpsh_pkg::BS_START) && !cfg_we;
    fill_we   = (bs_q == rpsh_pkg::BS_FILL) && draw.valid && !cfg_we;
    fill_done = fill_we && fs_last && fb_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q          <= rpsh_pkg::BS_IDLE;
      fb_q          <= '0;
      fs_q          <= '0;
      signs_ready_q <= 1'b0;
    end else begin
      bs_q <= bs_d;
      if (cfg_we)         signs_ready_q <= 1'b0;
      else if (fill_done) signs_ready_q <= 1'b1;
      if (tw_start) begin
        fb_q <= '0;
        fs_q <= '0;
      end else if (fill_we) begin
        if (fs_last) begin
          fs_q <= '0;
          fb_q <= fb_q + 1'b1;
        end else begin
          fs_q <= fs_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sign RAM: bit-masked write from the build, one registered read per sample.
  // ---------------------------------------------------------------------------
  logic [MAX_BITS-1:0] sign_mem [MAX_SPOTS];
  logic [MAX_BITS-1:0] sign_rd_q;
  logic [SPOT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_BITS; j++) begin
      if (fill_we && (fb_q == '0 || fb_q == BIT_W'(j))) begin
        sign_mem[fs_q][j] <= (fb_q == BIT_W'(j)) ? draw.sign : 1'b0;
      end
    end
    sign_rd_q <= sign_mem[cnt_q];
  end

  // ---------------------------------------------------------------------------
  // Sample path: stage 0 reads the sign word, stage 1 updates all sums.
  // ---------------------------------------------------------------------------
  logic                    accept, last;
  logic                    s1_v_q, s1_last_q;
  logic signed [SUM_W-1:0] s1_x_q;
  logic signed [SUM_W-1:0] sum_q [MAX_BITS];
  logic signed [SUM_W-1:0] sum_n [MAX_BITS];
  logic [MAX_BITS-1:0]     id_bits;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign last   = (NS_W'(cnt_q) == ns_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_v_q    <= accept;
      s1_last_q <= accept && last;
      if (cfg_we)      cnt_q <= '0;
      else if (accept) cnt_q <= last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_x_q <= SUM_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  end

  always_comb begin
    for (int b = 0; b < MAX_BITS; b++) begin
      sum_n[b]   = sign_rd_q[b] ? sum_q[b] + s1_x_q : sum_q[b] - s1_x_q;
      id_bits[b] = !sum_n[b][SUM_W-1] && (NB_W'(b) < nb_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BITS; b++) sum_q[b] <= '0;
    end else begin
      for (int b = 0; b < MAX_BITS; b++) begin
        if (cfg_we || (s1_v_q && s1_last_q)) sum_q[b] <= '0;
        else if (s1_v_q)                     sum_q[b] <= sum_n[b];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry; besides the build, input is held off when both
  // could end up full with a result still in stage 1.
  // ---------------------------------------------------------------------------
  logic [rpsh_pkg::ID_W-1:0] out_q, skid_q, id_new;
  logic                      out_v_q, skid_v_q, push, pop;
  logic [1:0]                occ;

  assign id_new = rpsh_pkg::ID_W'(id_bits);
  assign push   = s1_v_q && s1_last_q;
  assign pop    = out_v_q && m_axis_tready;
  assign occ    = {1'b0, out_v_q} + {1'b0, skid_v_q} + {1'b0, push} - {1'b0, pop};

  assign s_axis_tready = signs_ready_q && (bs_q == rpsh_pkg::BS_IDLE) && !occ[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= push;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      if (out_v_q) skid_v_q <= 1'b1;
      else         out_v_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (push) skid_q <= id_new;
      end else if (push) begin
        out_q <= id_new;
      end
    end else if (push) begin
      if (out_v_q) skid_q <= id_new;
      else         out_q  <= id_new;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(64 - rpsh_pkg::ID_W){1'b0}}, out_q};

endmodule
`default_nettype wire
